### hw/rtl/dali_address_commissioning_top_defines.svh
// Assertion macros used by the checker file of the commissioning block.
`ifndef DALI_ADDRESS_COMMISSIONING_TOP_DEFINES_SVH
`define DALI_ADDRESS_COMMISSIONING_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dac_pkg.sv
package dac_pkg;

    // Assignment stops once this many devices hold a short address.
    localparam int unsigned MAX_DEVICES = 64;

    localparam logic [23:0] SEARCH_TOP  = 24'hFFFFFF;
    localparam logic [23:0] SEARCH_HALF = 24'h800000;
    localparam logic [4:0]  LAST_BIT    = 5'd23;
    localparam logic [4:0]  END_BIT     = 5'd24;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_REPLY = 2'd1,
        CMD_ABORT = 2'd2
    } t_cmd;

    // What a queued job will emit; one-hot coded.
    typedef enum logic [5:0] {
        JK_START     = 6'b000001,
        JK_STEP      = 6'b000010,
        JK_FOUND     = 6'b000100,
        JK_FOUND_END = 6'b001000,
        JK_TERM      = 6'b010000,
        JK_ABORT     = 6'b100000
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [23:0] addr;     // search address (or found device address)
        logic [7:0]  scope;    // INITIALISE data byte
        logic [7:0]  prog;     // PROGRAM SHORT ADDRESS data byte
        logic [6:0]  cnt_old;  // device count before this job
        logic [6:0]  cnt_new;  // device count after a programming frame
    } t_job;

endpackage

### hw/rtl/dac_if.sv
interface dac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] search_scope;
    logic       reply_yes;

    modport source (output valid, command, search_scope, reply_yes, input ready);
    modport sink (input valid, command, search_scope, reply_yes, output ready);
endinterface

interface dac_out_if;
    logic       valid;
    logic       ready;
    logic       frame_valid;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
    logic       pause_after;
    logic       expects_reply;
    logic       run_done;
    logic       run_aborted;
    logic [6:0] devices_assigned;
    logic       last;

    modport source (
        output valid, frame_valid, address_byte, data_byte, pause_after,
               expects_reply, run_done, run_aborted, devices_assigned, last,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, address_byte, data_byte, pause_after,
               expects_reply, run_done, run_aborted, devices_assigned, last,
        output ready
    );
endinterface

### hw/rtl/dac_ctrl.sv
module dac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_data,
    input  logic          i_accept,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_scope,
    input  logic          i_reply_yes,
    output dac_pkg::t_job o_job,
    output logic          o_job_present
);

    logic [5:0]  r_first;
    logic        r_running,    n_running;
    logic [23:0] r_base,       n_base;
    logic [23:0] r_step,       n_step;
    logic [4:0]  r_bit,        n_bit;
    logic [6:0]  r_next_short, n_next_short;
    logic [6:0]  r_count,      n_count;

    logic [23:0] found_addr;
    logic [23:0] moved_base;
    logic [6:0]  count_inc;

    assign found_addr = i_reply_yes ? r_base : r_base + 24'd1;
    assign moved_base = i_reply_yes ? r_base - r_step : r_base + r_step;
    assign count_inc  = r_count + 7'd1;

    always_comb begin
        n_running        = r_running;
        n_base           = r_base;
        n_step           = r_step;
        n_bit            = r_bit;
        n_next_short     = r_next_short;
        n_count          = r_count;
        o_job_present    = 1'b0;
        o_job.kind       = dac_pkg::JK_TERM;
        o_job.addr       = r_base;
        o_job.scope      = i_scope;
        o_job.prog       = {r_next_short, 1'b1};
        o_job.cnt_old    = r_count;
        o_job.cnt_new    = count_inc;

        unique case (dac_pkg::t_cmd'(i_command))
            dac_pkg::CMD_START: begin
                n_running     = 1'b1;
                n_count       = 7'd0;
                n_next_short  = {1'b0, r_first};
                n_base        = dac_pkg::SEARCH_TOP;
                n_step        = dac_pkg::SEARCH_HALF;
                n_bit         = 5'd0;
                o_job_present = 1'b1;
                o_job.kind    = dac_pkg::JK_START;
                o_job.addr    = dac_pkg::SEARCH_TOP;
                o_job.cnt_old = 7'd0;
            end
            dac_pkg::CMD_REPLY: begin
                if (r_running) begin
                    o_job_present = 1'b1;
                    if (r_bit >= dac_pkg::END_BIT) begin
                        o_job.addr   = found_addr;
                        n_count      = count_inc;
                        n_next_short = r_next_short + 7'd1;
                        if (count_inc >= 7'(dac_pkg::MAX_DEVICES)) begin
                            n_running  = 1'b0;
                            o_job.kind = dac_pkg::JK_FOUND_END;
                        end else begin
                            n_base     = dac_pkg::SEARCH_TOP;
                            n_step     = dac_pkg::SEARCH_HALF;
                            n_bit      = 5'd0;
                            o_job.kind = dac_pkg::JK_FOUND;
                        end
                    end else if (!i_reply_yes && r_bit == 5'd0) begin
                        n_running  = 1'b0;
                        o_job.kind = dac_pkg::JK_TERM;
                    end else begin
                        n_base     = moved_base;
                        n_step     = (r_bit == dac_pkg::LAST_BIT) ? r_step : r_step >> 1;
                        n_bit      = r_bit + 5'd1;
                        o_job.kind = dac_pkg::JK_STEP;
                        o_job.addr = moved_base;
                    end
                end
            end
            dac_pkg::CMD_ABORT: begin
                if (r_running) begin
                    n_running     = 1'b0;
                    n_count       = 7'd0;
                    o_job_present = 1'b1;
                    o_job.kind    = dac_pkg::JK_ABORT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= 6'd0;
            r_running    <= 1'b0;
            r_base       <= dac_pkg::SEARCH_TOP;
            r_step       <= dac_pkg::SEARCH_HALF;
            r_bit        <= 5'd0;
            r_next_short <= 7'd0;
            r_count      <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                r_first <= i_cfg_data;
            end
            if (i_accept) begin
                r_running    <= n_running;
                r_base       <= n_base;
                r_step       <= n_step;
                r_bit        <= n_bit;
                r_next_short <= n_next_short;
                r_count      <= n_count;
            end
        end
    end

endmodule

### hw/rtl/dac_emit.sv
module dac_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  dac_pkg::t_job  i_job,
    output logic           o_take_ok,
    dac_out_if.source      o_out
);

    typedef enum logic [3:0] {
        FR_RESET, FR_RESET_PAUSE, FR_OFF, FR_INIT, FR_RAND, FR_SH, FR_SM, FR_SL,
        FR_CMP, FR_PROG, FR_WDRAW, FR_TERM, FR_ABORT
    } t_frame;

    // Extended command frames put (opcode - 256) << 1 into the 0xA1 pattern.
    localparam logic [7:0] ADDR_BCAST = 8'hFF;
    localparam logic [7:0] DATA_RESET = 8'h20;
    localparam logic [7:0] ADDR_TERM  = 8'hA1;
    localparam logic [7:0] ADDR_INIT  = 8'hA5;
    localparam logic [7:0] ADDR_RAND  = 8'hA7;
    localparam logic [7:0] ADDR_CMP   = 8'hA9;
    localparam logic [7:0] ADDR_WDRAW = 8'hAB;
    localparam logic [7:0] ADDR_SH    = 8'hB1;
    localparam logic [7:0] ADDR_SM    = 8'hB3;
    localparam logic [7:0] ADDR_SL    = 8'hB5;
    localparam logic [7:0] ADDR_PROG  = 8'hB7;

    dac_pkg::t_job r_job;
    logic          r_job_valid;
    logic [3:0]    r_idx;
    logic          r_out_valid;

    t_frame      frame;
    logic [3:0]  last_idx;
    logic        is_last;
    logic        advance;
    logic        found_kind;
    logic [23:0] sel_addr;
    logic        n_frame_valid, n_pause, n_expects, n_done, n_aborted;
    logic [7:0]  n_addr_byte, n_data_byte;
    logic [6:0]  n_count;

    assign advance    = r_job_valid && (!r_out_valid || o_out.ready);
    assign is_last    = (r_idx == last_idx);
    assign o_take_ok  = !r_job_valid || (advance && is_last);
    assign found_kind = (r_job.kind == dac_pkg::JK_FOUND) || (r_job.kind == dac_pkg::JK_FOUND_END);
    // After a found device the search restarts from the top of the range.
    assign sel_addr   = (found_kind && r_idx >= 4'd5) ? dac_pkg::SEARCH_TOP : r_job.addr;

    always_comb begin
        frame    = FR_TERM;
        last_idx = 4'd0;
        unique case (r_job.kind)
            dac_pkg::JK_START: begin
                last_idx = 4'd10;
                unique case (r_idx)
                    4'd0:       frame = FR_RESET;
                    4'd1:       frame = FR_RESET_PAUSE;
                    4'd2:       frame = FR_OFF;
                    4'd3, 4'd4: frame = FR_INIT;
                    4'd5, 4'd6: frame = FR_RAND;
                    4'd7:       frame = FR_SH;
                    4'd8:       frame = FR_SM;
                    4'd9:       frame = FR_SL;
                    default:    frame = FR_CMP;
                endcase
            end
            dac_pkg::JK_STEP: begin
                last_idx = 4'd3;
                unique case (r_idx)
                    4'd0:    frame = FR_SH;
                    4'd1:    frame = FR_SM;
                    4'd2:    frame = FR_SL;
                    default: frame = FR_CMP;
                endcase
            end
            dac_pkg::JK_FOUND, dac_pkg::JK_FOUND_END: begin
                last_idx = (r_job.kind == dac_pkg::JK_FOUND) ? 4'd8 : 4'd5;
                unique case (r_idx)
                    4'd0, 4'd5: frame = (r_job.kind == dac_pkg::JK_FOUND) ? FR_SH : FR_TERM;
                    4'd1, 4'd6: frame = FR_SM;
                    4'd2, 4'd7: frame = FR_SL;
                    4'd3:       frame = FR_PROG;
                    4'd4:       frame = FR_WDRAW;
                    default:    frame = FR_CMP;
                endcase
                if (r_idx == 4'd0) begin
                    frame = FR_SH;
                end
            end
            dac_pkg::JK_TERM:  frame = FR_TERM;
            dac_pkg::JK_ABORT: frame = FR_ABORT;
            default:           frame = FR_TERM;
        endcase
    end

    always_comb begin
        n_frame_valid = 1'b1;
        n_addr_byte   = ADDR_TERM;
        n_data_byte   = 8'd0;
        n_pause       = 1'b0;
        n_expects     = 1'b0;
        n_done        = 1'b0;
        n_aborted     = 1'b0;
        n_count       = (found_kind && r_idx >= 4'd3) ? r_job.cnt_new : r_job.cnt_old;
        unique case (frame)
            FR_RESET: begin
                n_addr_byte = ADDR_BCAST;
                n_data_byte = DATA_RESET;
            end
            FR_RESET_PAUSE: begin
                n_addr_byte = ADDR_BCAST;
                n_data_byte = DATA_RESET;
                n_pause     = 1'b1;
            end
            FR_OFF: n_addr_byte = ADDR_BCAST;
            FR_INIT: begin
                n_addr_byte = ADDR_INIT;
                n_data_byte = r_job.scope;
            end
            FR_RAND: n_addr_byte = ADDR_RAND;
            FR_SH: begin
                n_addr_byte = ADDR_SH;
                n_data_byte = sel_addr[23:16];
            end
            FR_SM: begin
                n_addr_byte = ADDR_SM;
                n_data_byte = sel_addr[15:8];
            end
            FR_SL: begin
                n_addr_byte = ADDR_SL;
                n_data_byte = sel_addr[7:0];
            end
            FR_CMP: begin
                n_addr_byte = ADDR_CMP;
                n_expects   = 1'b1;
            end
            FR_PROG: begin
                n_addr_byte = ADDR_PROG;
                n_data_byte = r_job.prog;
            end
            FR_WDRAW: n_addr_byte = ADDR_WDRAW;
            FR_TERM:  n_done      = 1'b1;
            FR_ABORT: begin
                n_frame_valid = 1'b0;
                n_addr_byte   = 8'd0;
                n_aborted     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_job_valid <= 1'b1;
                r_idx       <= 4'd0;
            end else if (advance) begin
                if (is_last) begin
                    r_job_valid <= 1'b0;
                    r_idx       <= 4'd0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (advance) begin
            o_out.frame_valid      <= n_frame_valid;
            o_out.address_byte     <= n_addr_byte;
            o_out.data_byte        <= n_data_byte;
            o_out.pause_after      <= n_pause;
            o_out.expects_reply    <= n_expects;
            o_out.run_done         <= n_done;
            o_out.run_aborted      <= n_aborted;
            o_out.devices_assigned <= n_count;
            o_out.last             <= is_last;
        end
    end

    assign o_out.valid = r_out_valid;

endmodule

### hw/rtl/dali_address_commissioning_top.sv
// Channel   Dir  Handshake        Beat contents
// i_in      in   valid / ready    command, search_scope, reply_yes
// o_out     out  valid / ready    one forward frame or status result, last marks the end
// i_cfg     in   i_cfg_we         first_short_address (6 bits)
//
// An input beat is taken on the valid / ready handshake and its results leave one per cycle
// while o_out is not stalled: one beat for a terminate or an abort, four for a search step,
// nine for a found device (six when it fills the bus) and eleven for a start. i_in.ready is
// high while no job is queued and in the cycle that the queued job's last result enters the
// output register, so the next beat can go in with the last result of the one before.
// Reset is synchronous and active low. A stalled output holds its beat and the sequencer.

module dali_address_commissioning_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dac_in_if.sink      i_in,
    dac_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data
);

    // Accepting a beat updates the search state at once; the emitted results are taken
    // from the job snapshot, so the state may run ahead of the frames still queued.
    dac_pkg::t_job job;
    logic          job_present;
    logic          take_ok;
    logic          accept;

    assign i_in.ready = take_ok;
    assign accept     = i_in.valid && take_ok;

    // Command decoding, binary search state and the short address counter.
    dac_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_command     (i_in.command),
        .i_scope       (i_in.search_scope),
        .i_reply_yes   (i_in.reply_yes),
        .o_job         (job),
        .o_job_present (job_present)
    );

    // Frame sequencer and output register. Items that cause no result are never queued.
    dac_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept && job_present),
        .i_job     (job),
        .o_take_ok (take_ok),
        .o_out     (o_out)
    );

endmodule

### hw/rtl/dac_checker.sv
`include "dali_address_commissioning_top_defines.svh"

module dac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_frame_valid,
    input logic [7:0] i_address_byte,
    input logic [7:0] i_data_byte,
    input logic       i_expects_reply,
    input logic       i_run_done,
    input logic       i_run_aborted,
    input logic [6:0] i_devices_assigned,
    input logic       i_last
);

    `DAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_address_byte) && $stable(i_data_byte) && $stable(i_last), "stalled result changed")
    `DAC_ASSERT_SAME(a_compare_last, i_clk, i_rst_n, i_out_valid && i_expects_reply, i_frame_valid && i_last && i_address_byte == 8'hA9, "compare is not a final frame")
    `DAC_ASSERT_SAME(a_abort_shape, i_clk, i_rst_n, i_out_valid && i_run_aborted, !i_frame_valid && i_last && !i_run_done, "malformed abort result")
    `DAC_ASSERT_SAME(a_done_shape, i_clk, i_rst_n, i_out_valid && i_run_done, i_last && i_address_byte == 8'hA1 && i_devices_assigned <= 7'd64, "malformed terminate result")

endmodule

bind dali_address_commissioning_top dac_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_frame_valid      (o_out.frame_valid),
    .i_address_byte     (o_out.address_byte),
    .i_data_byte        (o_out.data_byte),
    .i_expects_reply    (o_out.expects_reply),
    .i_run_done         (o_out.run_done),
    .i_run_aborted      (o_out.run_aborted),
    .i_devices_assigned (o_out.devices_assigned),
    .i_last             (o_out.last)
);

### sim/tb.sv
// Testbench for the DALI short-address commissioning sequencer.
//
// Input beats come from a queue that the stimulus block below fills, one
// phase per setting of the first short address. The driver takes the next
// beat from that queue and works out the frames that the beat must cause.
// Those frames go into a queue of their own, because a beat that is driven
// is always accepted, in order. The monitor checks every result beat, field
// by field, against the oldest frame in that queue. Both sides stall in
// random bursts, except in the last phase.

module tb;
    import dac_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_PRINTS   = 30;
    localparam int unsigned SEARCH_BEATS = 25;  // compare replies for one device

    // The command code that the block has no use for.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Broadcast frames of the opening sequence.
    localparam logic [7:0] BCAST_ADDR = 8'hFF;
    localparam logic [7:0] DALI_RESET = 8'd32;
    localparam logic [7:0] DALI_OFF   = 8'd0;

    // Special commands. Each one is sent on an address byte of 0xA1 plus
    // twice its distance from TERMINATE.
    localparam logic [7:0] EXT_ADDR_BASE  = 8'hA1;
    localparam int         EXT_TERMINATE  = 256;
    localparam int         EXT_INITIALISE = 258;
    localparam int         EXT_RANDOMISE  = 259;
    localparam int         EXT_COMPARE    = 260;
    localparam int         EXT_WITHDRAW   = 261;
    localparam int         EXT_SEARCH_H   = 264;
    localparam int         EXT_SEARCH_M   = 265;
    localparam int         EXT_SEARCH_L   = 266;
    localparam int         EXT_PROGRAM    = 267;

    // Modes of a full search for one device.
    localparam int unsigned DEV_RANDOM  = 0;
    localparam int unsigned DEV_ALL_YES = 1;
    localparam int unsigned DEV_ALL_NO  = 2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] scope;
        logic       reply_yes;
    } t_cmd_beat;

    typedef struct packed {
        logic       frame_valid;
        logic [7:0] address_byte;
        logic [7:0] data_byte;
        logic       pause_after;
        logic       expects_reply;
        logic       run_done;
        logic       run_aborted;
        logic [6:0] devices_assigned;
        logic       last;
    } t_frame;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [5:0] i_cfg_data = 6'd0;

    dac_in_if  in_if ();
    dac_out_if out_if ();

    dali_address_commissioning_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Our own copy of the sequencer: its state and its one register.
    // ------------------------------------------------------------------
    logic        run_active  = 1'b0;
    logic [23:0] srch_base   = SEARCH_TOP;
    logic [23:0] srch_step   = SEARCH_HALF;
    logic [4:0]  srch_bit    = '0;
    logic [6:0]  next_short  = '0;
    logic [6:0]  dev_count   = '0;
    logic [5:0]  first_short = '0;

    t_frame    staged[$];      // frames of the beat being worked out
    t_frame    frames_due[$];  // frames driven but not yet seen at the output
    t_cmd_beat beats_to_send[$];

    int unsigned beats_queued  = 0;
    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned runs_finished = 0;
    int unsigned runs_aborted  = 0;
    int unsigned devices_total = 0;
    int unsigned settings_used = 0;
    int unsigned cycles        = 0;
    bit          quiet         = 1'b0;  // no stalls on either side
    bit          gen_running   = 1'b0;  // stimulus left a run open

    function automatic logic [7:0] ext_addr(input int code);
        return EXT_ADDR_BASE | 8'((code - EXT_TERMINATE) << 1);
    endfunction

    task automatic stage(input logic fv, input logic [7:0] a, input logic [7:0] d,
                         input logic pause, input logic reply, input logic done,
                         input logic aborted);
        t_frame f;
        f.frame_valid      = fv;
        f.address_byte     = a;
        f.data_byte        = d;
        f.pause_after      = pause;
        f.expects_reply    = reply;
        f.run_done         = done;
        f.run_aborted      = aborted;
        f.devices_assigned = dev_count;
        f.last             = 1'b0;
        staged.push_back(f);
    endtask

    task automatic stage_ext(input int code, input logic [7:0] d);
        stage(1'b1, ext_addr(code), d, 1'b0, code == EXT_COMPARE, 1'b0, 1'b0);
    endtask

    task automatic stage_search_addr(input logic [23:0] addr);
        stage_ext(EXT_SEARCH_H, addr[23:16]);
        stage_ext(EXT_SEARCH_M, addr[15:8]);
        stage_ext(EXT_SEARCH_L, addr[7:0]);
    endtask

    task automatic restart_search();
        srch_base = SEARCH_TOP;
        srch_step = SEARCH_HALF;
        srch_bit  = '0;
        stage_search_addr(srch_base);
        stage_ext(EXT_COMPARE, 8'h00);
    endtask

    task automatic end_run();
        stage(1'b1, ext_addr(EXT_TERMINATE), 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        run_active = 1'b0;
        runs_finished++;
    endtask

    // The device counts from its PROGRAM SHORT ADDRESS frame on.
    task automatic program_device(input logic [23:0] addr);
        stage_search_addr(addr);
        dev_count = dev_count + 7'd1;
        stage_ext(EXT_PROGRAM, {next_short, 1'b1});
        next_short = next_short + 7'd1;
        stage_ext(EXT_WITHDRAW, 8'h00);
        devices_total++;
        if (dev_count >= MAX_DEVICES) begin
            end_run();
        end else begin
            restart_search();
        end
    endtask

    // Works out the frames that one command beat causes and queues them.
    task automatic predict_frames(input t_cmd_beat b);
        logic [4:0] n;
        logic       settled;
        t_frame     f;
        n       = srch_bit;
        settled = 1'b0;
        case (b.command)
            CMD_START: begin
                run_active = 1'b1;
                dev_count  = '0;
                next_short = {1'b0, first_short};
                stage(1'b1, BCAST_ADDR, DALI_RESET, 1'b0, 1'b0, 1'b0, 1'b0);
                stage(1'b1, BCAST_ADDR, DALI_RESET, 1'b1, 1'b0, 1'b0, 1'b0);
                stage(1'b1, BCAST_ADDR, DALI_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
                stage_ext(EXT_INITIALISE, b.scope);
                stage_ext(EXT_INITIALISE, b.scope);
                stage_ext(EXT_RANDOMISE, 8'h00);
                stage_ext(EXT_RANDOMISE, 8'h00);
                restart_search();
            end
            CMD_REPLY: begin
                if (run_active) begin
                    // Past the last bit a reply places the device at the base,
                    // silence places it one above.
                    if (b.reply_yes) begin
                        if (n >= END_BIT) begin
                            program_device(srch_base);
                            settled = 1'b1;
                        end else begin
                            srch_base = srch_base - srch_step;
                        end
                    end else begin
                        if (n == '0) begin
                            end_run();
                            settled = 1'b1;
                        end else if (n >= END_BIT) begin
                            program_device(srch_base + 24'd1);
                            settled = 1'b1;
                        end else begin
                            srch_base = srch_base + srch_step;
                        end
                    end
                    if (!settled) begin
                        if (n != LAST_BIT) begin
                            srch_step = srch_step >> 1;
                        end
                        srch_bit = n + 5'd1;
                        stage_search_addr(srch_base);
                        stage_ext(EXT_COMPARE, 8'h00);
                    end
                end
            end
            CMD_ABORT: begin
                if (run_active) begin
                    stage(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                    run_active = 1'b0;
                    dev_count  = '0;
                    runs_aborted++;
                end
            end
            default: ;
        endcase
        while (staged.size() > 0) begin
            f      = staged.pop_front();
            f.last = (staged.size() == 0);
            frames_due.push_back(f);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            report_mismatch($sformatf("result beat %0d, %s expected 0x%0h, got 0x%0h",
                                      results_seen, name, want, got));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. A beat is predicted when it goes onto the bus: it will be
    // accepted in that order, and its frames cannot show up any sooner.
    // ------------------------------------------------------------------
    int unsigned in_gap = 0;

    always @(posedge i_clk) begin
        t_cmd_beat b;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.command      <= CMD_START;
            in_if.search_scope <= 8'h00;
            in_if.reply_yes    <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                beats_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (beats_to_send.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        // A gap with valid held low, this cycle included.
                        in_gap = $urandom_range(0, 6);
                        in_if.valid <= 1'b0;
                    end else begin
                        b = beats_to_send.pop_front();
                        predict_frames(b);
                        in_if.command      <= b.command;
                        in_if.search_scope <= b.scope;
                        in_if.reply_yes    <= b.reply_yes;
                        in_if.valid        <= 1'b1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and output stalls.
    // ------------------------------------------------------------------
    int unsigned out_stall = 0;

    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (frames_due.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_valid", want.frame_valid, out_if.frame_valid);
                    check_field("address_byte", want.address_byte, out_if.address_byte);
                    check_field("data_byte", want.data_byte, out_if.data_byte);
                    check_field("pause_after", want.pause_after, out_if.pause_after);
                    check_field("expects_reply", want.expects_reply, out_if.expects_reply);
                    check_field("run_done", want.run_done, out_if.run_done);
                    check_field("run_aborted", want.run_aborted, out_if.run_aborted);
                    check_field("devices_assigned", want.devices_assigned,
                                out_if.devices_assigned);
                    check_field("last", want.last, out_if.last);
                end
                results_seen++;
            end
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(0, 6);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [1:0] cmd, input logic [7:0] scope,
                              input logic yes);
        t_cmd_beat b;
        b.command   = cmd;
        b.scope     = scope;
        b.reply_yes = yes;
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    // The scope byte rides along on every beat but only START uses it.
    task automatic queue_reply(input logic yes);
        queue_beat(CMD_REPLY, 8'($urandom), yes);
    endtask

    // A beat that the block should drop while no run is open.
    task automatic queue_idle_noise();
        case ($urandom_range(0, 2))
            0:       queue_beat(CMD_REPLY, 8'($urandom), 1'($urandom));
            1:       queue_beat(CMD_ABORT, 8'($urandom), 1'($urandom));
            default: queue_beat(CMD_UNUSED, 8'($urandom), 1'($urandom));
        endcase
    endtask

    // A full search that ends with one device programmed. The first compare
    // must get an answer, or the run would end instead.
    task automatic queue_device(input int unsigned mode);
        queue_reply(1'b1);
        for (int unsigned i = 1; i < SEARCH_BEATS; i++) begin
            if (mode == DEV_ALL_YES) begin
                queue_reply(1'b1);
            end else if (mode == DEV_ALL_NO) begin
                queue_reply(1'b0);
            end else begin
                queue_reply(1'($urandom));
                if ($urandom_range(0, 15) == 0) begin
                    queue_beat(CMD_UNUSED, 8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // START, at most one device, then a TERMINATE, an abort part way through
    // a search, or a run left open for the next START to restart.
    task automatic queue_session();
        logic [7:0]  scope;
        int unsigned ending;
        int unsigned pick;
        case ($urandom_range(0, 5))
            0:       scope = 8'h00;
            1:       scope = 8'hFF;
            default: scope = 8'($urandom);
        endcase
        queue_beat(CMD_START, scope, 1'($urandom));
        repeat ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 7);
            queue_device(pick == 0 ? DEV_ALL_YES : pick == 1 ? DEV_ALL_NO : DEV_RANDOM);
        end
        ending = $urandom_range(0, 9);
        if (ending < 6) begin
            queue_reply(1'b0);
            gen_running = 1'b0;
            if ($urandom_range(0, 2) == 0) begin
                queue_idle_noise();
            end
        end else begin
            queue_reply(1'b1);
            repeat ($urandom_range(0, 22)) begin
                queue_reply(1'($urandom));
            end
            if (ending < 9) begin
                queue_beat(CMD_ABORT, 8'($urandom), 1'($urandom));
                gen_running = 1'b0;
                if ($urandom_range(0, 1) == 0) begin
                    queue_idle_noise();
                end
            end else begin
                gen_running = 1'b1;
            end
        end
    endtask

    // Waits until every beat has gone in and every frame has come out, then
    // gives beats that cause no frame time to pass through.
    task automatic wait_drained();
        while (!(beats_sent == beats_queued && frames_due.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned target);
        int unsigned base_count;
        base_count = beats_queued;
        while (beats_queued - base_count < target) begin
            queue_session();
        end
        if (gen_running) begin
            queue_beat(CMD_ABORT, 8'($urandom), 1'($urandom));
            gen_running = 1'b0;
        end
        wait_drained();
    endtask

    // Written only while the block is idle; the sequencer reads the register
    // when a run starts.
    task automatic load_first_short(input logic [5:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        first_short = value;
        settings_used++;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Beats that arrive with no run open are dropped.
        load_first_short(6'd0);
        queue_beat(CMD_REPLY, 8'hFF, 1'b1);
        queue_beat(CMD_ABORT, 8'h00, 1'b0);
        queue_beat(CMD_UNUSED, 8'hFF, 1'b1);
        // No answer to the very first compare ends the run at once.
        queue_beat(CMD_START, 8'h00, 1'b0);
        queue_reply(1'b0);
        // An abort part way through a search.
        queue_beat(CMD_START, 8'hFF, 1'b1);
        queue_reply(1'b1);
        queue_reply(1'b0);
        queue_reply(1'b1);
        queue_beat(CMD_ABORT, 8'h00, 1'b0);
        queue_beat(CMD_ABORT, 8'hFF, 1'b1);
        // START while a run is open begins the whole sequence again.
        queue_beat(CMD_START, 8'hA5, 1'b0);
        queue_reply(1'b1);
        queue_beat(CMD_START, 8'h5A, 1'b1);
        queue_beat(CMD_UNUSED, 8'h00, 1'b0);
        queue_reply(1'b0);
        queue_reply(1'b1);
        wait_drained();

        // Highest first address. The search climbs all the way up to the top
        // address for one device; the abort then reports a count of one.
        load_first_short(6'd63);
        queue_beat(CMD_START, 8'h3C, 1'b0);
        queue_device(DEV_ALL_NO);
        queue_beat(CMD_ABORT, 8'hC3, 1'b1);
        wait_drained();

        load_first_short(6'($urandom_range(1, 62)));
        run_random_phase(20);

        // Last phase with no stalls on either side.
        quiet = 1'b1;
        load_first_short(6'($urandom_range(0, 63)));
        run_random_phase(20);

        if (frames_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected result beats never arrived",
                                      frames_due.size()));
        end

        $display("Summary: %0d command beats in, %0d result beats checked, %0d register settings.",
                 beats_sent, results_seen, settings_used);
        $display("Summary: %0d devices programmed, %0d runs terminated, %0d runs aborted.",
                 devices_total, runs_finished, runs_aborted);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
